FILE: rtl/tevq_pkg.sv
package tevq_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_FIRES_DEF   = 63;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_DEL1   = 3'd1;
    localparam logic [2:0] ACT_DELALL = 3'd2;
    localparam logic [2:0] ACT_QUERY  = 3'd3;
    localparam logic [2:0] ACT_ADV    = 3'd4;

    localparam logic [2:0] KIND_RANGED   = 3'd1;
    localparam logic [2:0] KIND_RANGE_END = 3'd2;
    localparam logic [2:0] KIND_PERIODIC = 3'd3;
    localparam logic [2:0] KIND_DAILY    = 3'd4;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_DEFER = 2'd3;

    localparam logic [7:0] CFG_HOLD = 8'd0;
    localparam logic [7:0] CFG_DAY  = 8'd1;

    typedef struct packed {
        logic        marked;
        logic [7:0]  cb;
        logic [2:0]  kind;
        logic [31:0] period;
        logic [31:0] param;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  kind;
        logic [7:0]  cb;
        logic [31:0] stamp;
        logic [31:0] param;
        logic [31:0] period;
        logic [31:0] amount;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [7:0]  cb;
        logic [31:0] param;
        logic [31:0] stamp;
        logic [2:0]  kind;
        logic [31:0] clock_now;
        logic        due;
        logic        more;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        hold;
        logic [19:0] day;
    } cfg_t;

endpackage

FILE: rtl/tevq_ram.sv
module tevq_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/tevq_ctrl.sv
module tevq_ctrl
    import tevq_pkg::*;
    #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_FIRES   = MAX_FIRES_DEF,
    localparam int IDX_W = $clog2(TABLE_DEPTH),
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
    localparam int K_W   = $clog2(MAX_FIRES + 1)
    )
    (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             req,
    input  cfg_t             cfg,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res,
    output logic             ram_we,
    output logic [IDX_W-1:0] ram_waddr,
    output entry_t           ram_wdata,
    output logic [IDX_W-1:0] ram_raddr,
    input  entry_t           ram_rdata
    );

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_INS_RD  = 13'b0000000000010,
        S_INS_EV  = 13'b0000000000100,
        S_CMP_RD  = 13'b0000000001000,
        S_CMP_EV  = 13'b0000000010000,
        S_QRY     = 13'b0000000100000,
        S_ADV_RD  = 13'b0000001000000,
        S_ADV_EV  = 13'b0000010000000,
        S_REPOST  = 13'b0000100000000,
        S_FIRE    = 13'b0001000000000,
        S_ADV_END = 13'b0010000000000,
        S_ADV_FIN = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    typedef enum logic [3:0] {
        CM_DEL1   = 4'b0001,
        CM_DELALL = 4'b0010,
        CM_PURGE  = 4'b0100,
        CM_REMOVE = 4'b1000
    } cmode_t;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [K_W-1:0]   FIRE_CAP = K_W'(MAX_FIRES);

    state_t            state_reg, state_next;
    cmode_t            mode_reg, mode_next;
    req_t              req_reg, req_next;
    entry_t            ins_reg, ins_next;
    entry_t            fire_reg, fire_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [31:0]       clock_reg, clock_next;
    logic [31:0]       target_reg, target_next;
    logic              pending_reg, pending_next;
    logic              found_reg, found_next;
    logic              more_reg, more_next;
    logic              due_reg, due_next;
    logic [1:0]        status_reg, status_next;

    logic [32:0] sum33;
    logic [32:0] add33;
    logic        match;
    logic        drop;
    entry_t      kept;
    logic        repost_ok;

    always_comb
    begin
        if (fire_reg.kind == KIND_DAILY)
        begin
            add33 = {13'd0, cfg.day};
        end
        else
        begin
            add33 = {1'b0, fire_reg.period};
        end
        sum33 = {1'b0, fire_reg.stamp} + add33;
        repost_ok = !sum33[32] && (sum33[31:0] > fire_reg.stamp) && (count_reg != FULL_CNT)
            && (fire_reg.kind == KIND_RANGED || fire_reg.kind == KIND_PERIODIC
                || fire_reg.kind == KIND_DAILY);
    end

    always_comb
    begin
        match = 1'b0;
        drop  = 1'b0;
        kept  = ram_rdata;
        case (mode_reg)
            CM_DEL1:
            begin
                match = !found_reg && ram_rdata.cb == req_reg.cb
                    && ram_rdata.param == req_reg.param && !ram_rdata.marked;
            end
            CM_DELALL:
            begin
                match = ram_rdata.cb == req_reg.cb && !ram_rdata.marked;
            end
            CM_PURGE:
            begin
                drop = ram_rdata.marked;
            end
            CM_REMOVE:
            begin
                drop = (r_reg == i_reg);
            end
            default:
            begin
                drop = 1'b0;
            end
        endcase
        if (match)
        begin
            if (cfg.hold)
            begin
                kept.marked = 1'b1;
            end
            else
            begin
                drop = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        req_next     = req_reg;
        ins_next     = ins_reg;
        fire_next    = fire_reg;
        count_next   = count_reg;
        j_next       = j_reg;
        r_next       = r_reg;
        w_next       = w_reg;
        i_next       = i_reg;
        k_next       = k_reg;
        clock_next   = clock_reg;
        target_next  = target_reg;
        pending_next = pending_reg;
        found_next   = found_reg;
        more_next    = more_reg;
        due_next     = due_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = ins_reg;
        ram_raddr    = '0;
        in_ready     = (state_reg == S_IDLE);
        res_valid    = 1'b0;
        res          = '0;
        res.clock_now = clock_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = req;
                    status_next = ST_DONE;
                    due_next    = 1'b0;
                    more_next   = 1'b0;
                    found_next  = 1'b0;
                    case (req.action)
                        ACT_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ins_next = {1'b0, req.cb, req.kind, req.period, req.param,
                                            req.stamp};
                                j_next     = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_DEL1, ACT_DELALL:
                        begin
                            mode_next   = (req.action == ACT_DEL1) ? CM_DEL1 : CM_DELALL;
                            status_next = ST_NONE;
                            r_next      = '0;
                            w_next      = '0;
                            state_next  = S_CMP_RD;
                        end
                        ACT_QUERY:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_QRY;
                        end
                        ACT_ADV:
                        begin
                            if ({1'b0, clock_reg} + {1'b0, req.amount} > 33'hFFFFFFFF)
                            begin
                                target_next = 32'hFFFFFFFF;
                            end
                            else
                            begin
                                target_next = clock_reg + req.amount;
                            end
                            i_next     = '0;
                            k_next     = '0;
                            state_next = S_ADV_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_QRY:
            begin
                due_next   = ({1'b0, ram_rdata.stamp} <= {1'b0, clock_reg} + {1'b0, req_reg.amount});
                state_next = S_DONE;
            end
            S_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                    ram_wdata  = ins_reg;
                    count_next = count_reg + 1'b1;
                    state_next = (req_reg.action == ACT_ADV) ? S_FIRE : S_DONE;
                end
                else
                begin
                    ram_raddr  = IDX_W'(j_reg - 1'b1);
                    state_next = S_INS_EV;
                end
            end
            S_INS_EV:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(j_reg);
                if (ram_rdata.stamp > ins_reg.stamp)
                begin
                    ram_wdata  = ram_rdata;
                    j_next     = j_reg - 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    ram_wdata  = ins_reg;
                    count_next = count_reg + 1'b1;
                    state_next = (req_reg.action == ACT_ADV) ? S_FIRE : S_DONE;
                end
            end
            S_CMP_RD:
            begin
                if (r_reg == count_reg)
                begin
                    count_next = w_reg;
                    case (mode_reg)
                        CM_PURGE:
                        begin
                            pending_next = 1'b0;
                            state_next   = S_ADV_FIN;
                        end
                        CM_REMOVE:
                        begin
                            state_next = S_REPOST;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else
                begin
                    ram_raddr  = IDX_W'(r_reg);
                    state_next = S_CMP_EV;
                end
            end
            S_CMP_EV:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    if (cfg.hold)
                    begin
                        status_next  = ST_DEFER;
                        pending_next = 1'b1;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                    end
                end
                if (!drop)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IDX_W'(w_reg);
                    ram_wdata = kept;
                    w_next    = w_reg + 1'b1;
                end
                r_next     = r_reg + 1'b1;
                state_next = S_CMP_RD;
            end
            S_ADV_RD:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = S_ADV_END;
                end
                else
                begin
                    ram_raddr  = IDX_W'(i_reg);
                    state_next = S_ADV_EV;
                end
            end
            S_ADV_EV:
            begin
                if (ram_rdata.stamp > target_reg)
                begin
                    state_next = S_ADV_END;
                end
                else if (ram_rdata.marked)
                begin
                    if (ram_rdata.stamp > clock_reg)
                    begin
                        clock_next = ram_rdata.stamp;
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = S_ADV_RD;
                end
                else if (k_reg == FIRE_CAP)
                begin
                    more_next  = 1'b1;
                    state_next = S_ADV_END;
                end
                else
                begin
                    if (ram_rdata.stamp > clock_reg)
                    begin
                        clock_next = ram_rdata.stamp;
                    end
                    fire_next  = ram_rdata;
                    mode_next  = CM_REMOVE;
                    r_next     = i_reg;
                    w_next     = i_reg;
                    state_next = S_CMP_RD;
                end
            end
            S_REPOST:
            begin
                if (repost_ok)
                begin
                    ins_next.marked = 1'b0;
                    ins_next.cb     = fire_reg.cb;
                    ins_next.param  = fire_reg.param;
                    ins_next.stamp  = sum33[31:0];
                    if (fire_reg.kind == KIND_PERIODIC)
                    begin
                        ins_next.kind   = KIND_PERIODIC;
                        ins_next.period = fire_reg.period;
                    end
                    else
                    begin
                        ins_next.kind   = (fire_reg.kind == KIND_RANGED) ? KIND_RANGE_END
                                                                         : KIND_DAILY;
                        ins_next.period = '0;
                    end
                    j_next     = count_reg;
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_FIRE;
                end
            end
            S_FIRE:
            begin
                res_valid  = 1'b1;
                res.fired  = 1'b1;
                res.cb     = fire_reg.cb;
                res.param  = fire_reg.param;
                res.stamp  = fire_reg.stamp;
                res.kind   = fire_reg.kind;
                if (res_ready)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_ADV_RD;
                end
            end
            S_ADV_END:
            begin
                if (pending_reg)
                begin
                    mode_next  = CM_PURGE;
                    r_next     = '0;
                    w_next     = '0;
                    state_next = S_CMP_RD;
                end
                else
                begin
                    state_next = S_ADV_FIN;
                end
            end
            S_ADV_FIN:
            begin
                if (!more_reg)
                begin
                    clock_next = target_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid  = 1'b1;
                res.status = status_reg;
                res.due    = due_reg;
                res.more   = more_reg;
                res.last   = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= CM_DEL1;
            count_reg   <= '0;
            clock_reg   <= '0;
            pending_reg <= 1'b0;
            k_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            r_reg       <= '0;
            w_reg       <= '0;
            found_reg   <= 1'b0;
            more_reg    <= 1'b0;
            due_reg     <= 1'b0;
            status_reg  <= ST_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            clock_reg   <= clock_next;
            pending_reg <= pending_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            r_reg       <= r_next;
            w_reg       <= w_next;
            found_reg   <= found_next;
            more_reg    <= more_next;
            due_reg     <= due_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        ins_reg    <= ins_next;
        fire_reg   <= fire_next;
        target_reg <= target_next;
    end

endmodule

FILE: rtl/timed_event_queue.sv
// insert and delete walk the table through the table memory, which has one read port
// and one write port, reading an entry in one state and acting on it in the next; query
// and unknown actions do not walk the table
// advance: one walk per fired event and per repost, plus a purge walk for held deletes
// one request at a time; a result may wait in the output register while the next is taken
// reset: table empty, clock zero, hold_deletions 0, day_length 86400; no clearing pass
module timed_event_queue
    import tevq_pkg::*;
    #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_FIRES   = MAX_FIRES_DEF
    )
    (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // callback_id, time_stamp, event_param, period, time_amount
    input  logic [135:0] s_tdata,
    // action, event_kind
    input  logic [5:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // fired_callback, fired_param, fired_stamp, fired_kind, clock_now, due_pending,
    // more_due, zero fill
    output logic [111:0] m_tdata,
    // status, fired
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [19:0]  cfg_data
    );

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    cfg_t             cfg_reg;
    req_t             req;
    res_t             res;
    res_t             out_reg;
    logic             out_valid_reg;
    logic             res_valid;
    logic             res_ready;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold <= 1'b0;
            cfg_reg.day  <= 20'd86400;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_HOLD)
            begin
                cfg_reg.hold <= cfg_data[0];
            end
            else if (cfg_index == CFG_DAY)
            begin
                cfg_reg.day <= cfg_data;
            end
        end
    end

    assign req.action = s_tuser[2:0];
    assign req.kind   = s_tuser[5:3];
    assign req.cb     = s_tdata[7:0];
    assign req.stamp  = s_tdata[39:8];
    assign req.param  = s_tdata[71:40];
    assign req.period = s_tdata[103:72];
    assign req.amount = s_tdata[135:104];

    tevq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tevq_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_FIRES   (MAX_FIRES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req       (req),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = {out_reg.fired, out_reg.status};
    assign m_tdata  = {3'd0, out_reg.more, out_reg.due, out_reg.clock_now, out_reg.kind,
                       out_reg.stamp, out_reg.param, out_reg.cb};

endmodule

FILE: verif/timed_event_queue_tb.sv
`timescale 1ns / 1ps

module timed_event_queue_tb;
    import tevq_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int FIRE_CAP = MAX_FIRES_DEF;
    localparam logic [2:0] KIND_ONCE = 3'd0;
    localparam logic [7:0] CFG_SPARE = 8'd2;
    localparam logic [32:0] STAMP_TOP = 33'h0_FFFF_FFFF;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [135:0] s_tdata;
    logic [5:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [111:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic [7:0] cfg_index;
    logic [19:0] cfg_data;

    timed_event_queue u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // scheduler shadow state
    logic [31:0] ev_stamp [DEPTH];
    logic [31:0] ev_param [DEPTH];
    logic [31:0] ev_period [DEPTH];
    logic [2:0] ev_kind [DEPTH];
    logic [7:0] ev_cb [DEPTH];
    logic ev_marked [DEPTH];
    int ev_count;
    logic [31:0] now_s;
    logic purge_due;
    logic hold_del;
    logic [19:0] day_len;

    req_t pending_reqs[$];
    res_t expected_res[$];
    req_t cur_req;
    int errors;
    int reqs_sent;
    int res_seen;
    int fires_seen;
    int burst_left;
    int gap_left;
    int stall_cnt;
    int stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void push_result(logic [1:0] status, logic fired, logic [7:0] cb,
                                        logic [31:0] pa, logic [31:0] st, logic [2:0] kd,
                                        logic due, logic more, logic last);
        res_t r;
        r.status = status;
        r.fired = fired;
        r.cb = cb;
        r.param = pa;
        r.stamp = st;
        r.kind = kd;
        r.clock_now = now_s;
        r.due = due;
        r.more = more;
        r.last = last;
        expected_res.insert(expected_res.size(), r);
    endfunction

    function automatic void ev_remove(int idx);
        for (int j = idx; j + 1 < ev_count; j++)
        begin
            ev_stamp[j] = ev_stamp[j + 1];
            ev_param[j] = ev_param[j + 1];
            ev_period[j] = ev_period[j + 1];
            ev_kind[j] = ev_kind[j + 1];
            ev_cb[j] = ev_cb[j + 1];
            ev_marked[j] = ev_marked[j + 1];
        end
        ev_count--;
    endfunction

    function automatic bit ev_insert(logic [2:0] kd, logic [7:0] cb, logic [31:0] st,
                                     logic [31:0] pa, logic [31:0] pe);
        int pos;
        if (ev_count >= DEPTH)
            return 1'b0;
        pos = 0;
        while (pos < ev_count && ev_stamp[pos] <= st)
            pos++;
        for (int j = ev_count; j > pos; j--)
        begin
            ev_stamp[j] = ev_stamp[j - 1];
            ev_param[j] = ev_param[j - 1];
            ev_period[j] = ev_period[j - 1];
            ev_kind[j] = ev_kind[j - 1];
            ev_cb[j] = ev_cb[j - 1];
            ev_marked[j] = ev_marked[j - 1];
        end
        ev_stamp[pos] = st;
        ev_param[pos] = pa;
        ev_period[pos] = pe;
        ev_kind[pos] = kd;
        ev_cb[pos] = cb;
        ev_marked[pos] = 1'b0;
        ev_count++;
        return 1'b1;
    endfunction

    function automatic void ev_repost(logic [2:0] kd, logic [7:0] cb, logic [31:0] base,
                                      logic [31:0] add, logic [31:0] pa, logic [31:0] pe);
        logic [32:0] s;
        s = {1'b0, base} + {1'b0, add};
        if (s > STAMP_TOP || s <= {1'b0, base})
            return;
        void'(ev_insert(kd, cb, s[31:0], pa, pe));
    endfunction

    function automatic void run_advance(logic [31:0] amount);
        logic [32:0] target;
        int i;
        int k;
        bit more;
        logic [31:0] st;
        logic [31:0] pa;
        logic [31:0] pe;
        logic [2:0] kd;
        logic [7:0] cb;
        int j;
        target = {1'b0, now_s} + {1'b0, amount};
        if (target > STAMP_TOP)
            target = STAMP_TOP;
        i = 0;
        k = 0;
        more = 1'b0;
        while (i < ev_count && {1'b0, ev_stamp[i]} <= target)
        begin
            st = ev_stamp[i];
            pa = ev_param[i];
            pe = ev_period[i];
            kd = ev_kind[i];
            cb = ev_cb[i];
            if (ev_marked[i])
            begin
                if (st > now_s)
                    now_s = st;
                i++;
                continue;
            end
            if (k >= FIRE_CAP)
            begin
                more = 1'b1;
                break;
            end
            if (st > now_s)
                now_s = st;
            ev_remove(i);
            if (kd == KIND_RANGED)
                ev_repost(KIND_RANGE_END, cb, st, pe, pa, 32'd0);
            else if (kd == KIND_PERIODIC)
                ev_repost(KIND_PERIODIC, cb, st, pe, pa, pe);
            else if (kd == KIND_DAILY)
                ev_repost(KIND_DAILY, cb, st, {12'd0, day_len}, pa, 32'd0);
            push_result(ST_DONE, 1'b1, cb, pa, st, kd, 1'b0, 1'b0, 1'b0);
            k++;
        end
        if (purge_due)
        begin
            j = 0;
            while (j < ev_count)
            begin
                if (ev_marked[j])
                    ev_remove(j);
                else
                    j++;
            end
            purge_due = 1'b0;
        end
        if (!more)
            now_s = target[31:0];
        push_result(ST_DONE, 1'b0, 8'd0, 32'd0, 32'd0, 3'd0, 1'b0, more, 1'b1);
    endfunction

    function automatic void predict_request(req_t r);
        logic [1:0] status;
        logic due;
        int i;
        status = ST_DONE;
        due = 1'b0;
        if (r.action == ACT_ADV)
        begin
            run_advance(r.amount);
            return;
        end
        if (r.action == ACT_INSERT)
        begin
            status = ev_insert(r.kind, r.cb, r.stamp, r.param, r.period) ? ST_DONE : ST_FULL;
        end
        else if (r.action == ACT_DEL1)
        begin
            status = ST_NONE;
            for (i = 0; i < ev_count; i++)
            begin
                if (ev_cb[i] == r.cb && ev_param[i] == r.param && !ev_marked[i])
                begin
                    if (hold_del)
                    begin
                        ev_marked[i] = 1'b1;
                        purge_due = 1'b1;
                        status = ST_DEFER;
                    end
                    else
                    begin
                        ev_remove(i);
                        status = ST_DONE;
                    end
                    break;
                end
            end
        end
        else if (r.action == ACT_DELALL)
        begin
            status = ST_NONE;
            i = 0;
            while (i < ev_count)
            begin
                if (ev_cb[i] == r.cb && !ev_marked[i])
                begin
                    if (hold_del)
                    begin
                        ev_marked[i] = 1'b1;
                        purge_due = 1'b1;
                        status = ST_DEFER;
                        i++;
                    end
                    else
                    begin
                        ev_remove(i);
                        status = ST_DONE;
                    end
                end
                else
                begin
                    i++;
                end
            end
        end
        else if (r.action == ACT_QUERY)
        begin
            if (ev_count > 0 && {1'b0, ev_stamp[0]} <= {1'b0, now_s} + {1'b0, r.amount})
                due = 1'b1;
        end
        push_result(status, 1'b0, 8'd0, 32'd0, 32'd0, 3'd0, due, 1'b0, 1'b1);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left <= 1;
            gap_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_request(cur_req);
                reqs_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.amount, cur_req.period, cur_req.param,
                                cur_req.stamp, cur_req.cb};
                    s_tuser <= {cur_req.kind, cur_req.action};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_cnt <= 0;
            stall_mode <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                res_seen++;
                if (m_tuser[2])
                    fires_seen++;
                if (expected_res.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h %0h %0b",
                             $time, m_tuser, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    res_t w;
                    w = expected_res.pop_front();
                    check_field("status", 32'(w.status), 32'(m_tuser[1:0]));
                    check_field("fired", 32'(w.fired), 32'(m_tuser[2]));
                    check_field("fired_callback", 32'(w.cb), 32'(m_tdata[7:0]));
                    check_field("fired_param", w.param, m_tdata[39:8]);
                    check_field("fired_stamp", w.stamp, m_tdata[71:40]);
                    check_field("fired_kind", 32'(w.kind), 32'(m_tdata[74:72]));
                    check_field("clock_now", w.clock_now, m_tdata[106:75]);
                    check_field("due_pending", 32'(w.due), 32'(m_tdata[107]));
                    check_field("more_due", 32'(w.more), 32'(m_tdata[108]));
                    check_field("last", 32'(w.last), 32'(m_tlast));
                end
            end
            if (stall_cnt == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                stall_cnt <= $urandom_range(10, 80);
            end
            else
            begin
                stall_cnt <= stall_cnt - 1;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic add_req(logic [2:0] action, logic [2:0] kind, logic [7:0] cb,
                           logic [31:0] st, logic [31:0] pa, logic [31:0] pe,
                           logic [31:0] amount);
        req_t r;
        r.action = action;
        r.kind = kind;
        r.cb = cb;
        r.stamp = st;
        r.param = pa;
        r.period = pe;
        r.amount = amount;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_res.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [19:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_HOLD)
            hold_del = val[0];
        else if (idx == CFG_DAY)
            day_len = val;
    endtask

    task automatic add_random_req(bit wide);
        logic [2:0] action;
        logic [2:0] kind;
        logic [7:0] cb;
        logic [31:0] st;
        logic [31:0] pa;
        logic [31:0] pe;
        logic [31:0] amount;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            action = ACT_INSERT;
        else if (pick < 57)
            action = ACT_DEL1;
        else if (pick < 65)
            action = ACT_DELALL;
        else if (pick < 75)
            action = ACT_QUERY;
        else if (pick < 95)
            action = ACT_ADV;
        else
            action = 3'($urandom_range(5, 7));
        kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
        cb = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 7));
        pa = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 15);
        st = ($urandom_range(0, 9) == 0) ? $urandom() : now_s + $urandom_range(0, 3000);
        pe = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 400);
        if (wide && $urandom_range(0, 5) == 0)
            amount = $urandom();
        else
            amount = $urandom_range(0, 600);
        add_req(action, kind, cb, st, pa, pe, amount);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        reqs_sent = 0;
        res_seen = 0;
        fires_seen = 0;
        ev_count = 0;
        now_s = '0;
        purge_due = 1'b0;
        hold_del = 1'b0;
        day_len = 20'd86400;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty table, every kind, matches and misses, spare actions
        add_req(ACT_QUERY, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        add_req(ACT_ADV, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_req(ACT_INSERT, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_req(ACT_INSERT, KIND_RANGED, 8'd1, 32'd10, 32'hFFFF_FFFF, 32'd5, 32'd0);
        add_req(ACT_INSERT, KIND_RANGE_END, 8'd2, 32'd10, 32'd7, 32'd0, 32'd0);
        add_req(ACT_INSERT, KIND_PERIODIC, 8'd3, 32'd20, 32'd8, 32'd7, 32'd0);
        add_req(ACT_INSERT, KIND_PERIODIC, 8'd4, 32'd21, 32'd9, 32'd0, 32'd0);
        add_req(ACT_INSERT, KIND_DAILY, 8'd5, 32'd30, 32'd10, 32'd0, 32'd0);
        add_req(ACT_INSERT, 3'd7, 8'd255, 32'hFFFF_FFFF, 32'd11, 32'hFFFF_FFFF, 32'd0);
        add_req(ACT_INSERT, KIND_PERIODIC, 8'd6, 32'hFFFF_FFF0, 32'd12, 32'h20, 32'd0);
        add_req(ACT_QUERY, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_req(ACT_DEL1, KIND_ONCE, 8'd2, 32'd0, 32'd7, 32'd0, 32'd0);
        add_req(ACT_DEL1, KIND_ONCE, 8'd2, 32'd0, 32'd7, 32'd0, 32'd0);
        add_req(ACT_DELALL, KIND_ONCE, 8'd9, 32'd0, 32'd0, 32'd0, 32'd0);
        add_req(3'd5, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_req(3'd7, 3'd7, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(ACT_ADV, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd100);
        add_req(ACT_QUERY, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd86400);
        add_req(ACT_DELALL, KIND_ONCE, 8'd3, 32'd0, 32'd0, 32'd0, 32'd0);
        add_req(ACT_DELALL, KIND_ONCE, 8'd255, 32'd0, 32'd0, 32'd0, 32'd0);
        wait_idle();

        // deferred deletes with a short day
        write_reg(CFG_HOLD, 20'd1);
        write_reg(CFG_DAY, 20'd1);
        add_req(ACT_INSERT, KIND_ONCE, 8'd7, now_s + 5, 32'd1, 32'd0, 32'd0);
        add_req(ACT_INSERT, KIND_ONCE, 8'd7, now_s + 6, 32'd2, 32'd0, 32'd0);
        add_req(ACT_INSERT, KIND_DAILY, 8'd8, now_s + 7, 32'd3, 32'd0, 32'd0);
        add_req(ACT_DEL1, KIND_ONCE, 8'd7, 32'd0, 32'd1, 32'd0, 32'd0);
        add_req(ACT_QUERY, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd5);
        add_req(ACT_DELALL, KIND_ONCE, 8'd7, 32'd0, 32'd0, 32'd0, 32'd0);
        add_req(ACT_DELALL, KIND_ONCE, 8'd7, 32'd0, 32'd0, 32'd0, 32'd0);
        add_req(ACT_ADV, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd10);
        wait_idle();

        // fill past capacity, then hit the fire cap
        write_reg(CFG_HOLD, 20'd0);
        write_reg(CFG_DAY, 20'd1000000);
        for (int n = 0; n < DEPTH + 2; n++)
            add_req(ACT_INSERT, 3'($urandom_range(0, 4)), 8'($urandom_range(0, 7)),
                    now_s + $urandom_range(1, 40), $urandom_range(0, 15),
                    $urandom_range(1, 30), 32'd0);
        add_req(ACT_ADV, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd1000);
        add_req(ACT_ADV, KIND_ONCE, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        wait_idle();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_HOLD, 20'($urandom_range(0, 1)));
            write_reg(CFG_DAY, (ph == 0) ? 20'd1 : (ph == 1) ? 20'd1000000 :
                      20'($urandom_range(1, 1000000)));
            if (ph == 2)
                write_reg(CFG_SPARE, 20'($urandom_range(0, 20'hFFFFF)));
            for (int n = 0; n < 34; n++)
                add_random_req(ph == 3);
            wait_idle();
        end

        $display("requests sent: %0d, results checked: %0d, events fired: %0d",
                 reqs_sent, res_seen, fires_seen);
        $display("covered every action and kind, full table, fire cap, deferred deletes");
        if (errors == 0)
            $display("timed_event_queue test passed");
        else
            $display("timed_event_queue test failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("timed_event_queue test failed");
        $finish;
    end

endmodule

FILE: timed_event_queue.f
rtl/tevq_pkg.sv
rtl/tevq_ram.sv
rtl/tevq_ctrl.sv
rtl/timed_event_queue.sv
verif/timed_event_queue_tb.sv
